>>> rtl/core/gmw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gmw_pkg;

	localparam int MAX_SLOTS = 64;
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	localparam int CNT_W     = 7;
	localparam int IDX_W     = 8;
	localparam int MASK_BITS = 32;

	typedef enum logic [1:0] {
		CMD_BEGIN = 2'd0,
		CMD_MARK  = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_DRAIN = 2'd3
	} gmw_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DRAIN,
		ST_FLUSH
	} gmw_state_t;

	typedef struct packed {
		logic [1:0]           cmd;
		logic [IDX_W-1:0]     chunk_index;
		logic [MASK_BITS-1:0] source_mask;
	} gmw_in_t;

	typedef struct packed {
		logic                 added;
		logic                 found;
		logic [5:0]           slot_index;
		logic [MASK_BITS-1:0] slot_mask;
		logic                 last;
	} gmw_out_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic step;
	} gmw_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic drain_go;
		logic step_last;
	} gmw_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/generation_marked_worklist_core.sv
`timescale 1ns / 1ps
`default_nettype none

// per-frame deduplicating worklist over up to 64 chunk slots. an item is taken when start is
// high and busy is low; each result word shows on result for one cycle with result_strobe high
// and cannot be held off. begin_frame, mark and query keep busy high through the exec state
// after accept; a mark or query result word is registered from the exec state into result and
// result_strobe. drain walks the slot flags one per cycle up to the highest marked slot, limited
// by the single read port of the mask store. chunk_count is adopted at the next begin_frame; the
// user writes it only while idle, and the block itself does not enforce this.
module generation_marked_worklist_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire gmw_pkg::gmw_in_t          item,
	input  wire logic                      cfg_we,
	input  wire logic [gmw_pkg::CNT_W-1:0] cfg_wdata,
	output gmw_pkg::gmw_out_t              result,
	output logic                           result_strobe
);
	import gmw_pkg::*;

	gmw_ctl_t ctl;
	gmw_sts_t sts;

	gmw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctl    (ctl),
		.sts    (sts)
	);

	gmw_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.ctl           (ctl),
		.sts           (sts),
		.result        (result),
		.result_strobe (result_strobe)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_unfound_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.found |-> result.last)
		else $error("single-word result without last");

	a_added_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.added |-> !result.found && result.slot_mask != '0)
		else $error("added result carries found or empty mask");

	a_no_strobe_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !result_strobe)
		else $error("result word overlaps accept");

endmodule

`default_nettype wire

>>> rtl/core/gmw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module gmw_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output gmw_pkg::gmw_ctl_t      ctl,
	input  wire gmw_pkg::gmw_sts_t sts
);
	import gmw_pkg::*;

	gmw_state_t state_q;
	gmw_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				state_nxt = sts.drain_go ? ST_DRAIN : ST_IDLE;
			end
			ST_DRAIN: begin
				if (sts.step_last) state_nxt = ST_FLUSH;
			end
			ST_FLUSH: begin
				state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		busy     = 1'b1;
		ctl.load = 1'b0;
		ctl.exec = 1'b0;
		ctl.step = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				ctl.load = start;
			end
			ST_EXEC:  ctl.exec = 1'b1;
			ST_DRAIN: ctl.step = 1'b1;
			ST_FLUSH: busy = 1'b1;
			default:  busy = 1'b1;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/gmw_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module gmw_dp (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire gmw_pkg::gmw_in_t          item,
	input  wire logic                      cfg_we,
	input  wire logic [gmw_pkg::CNT_W-1:0] cfg_wdata,
	input  wire gmw_pkg::gmw_ctl_t         ctl,
	output gmw_pkg::gmw_sts_t              sts,
	output gmw_pkg::gmw_out_t              result,
	output logic                           result_strobe
);
	import gmw_pkg::*;

	logic [MASK_BITS-1:0] mask_mem [MAX_SLOTS];

	logic [1:0]           cmd_q;
	logic [IDX_W-1:0]     idx_q;
	logic [MASK_BITS-1:0] src_q;
	logic [MASK_BITS-1:0] rd_q;
	logic [CNT_W-1:0]     chunk_q;
	logic [CNT_W-1:0]     active_q;
	logic [MAX_SLOTS-1:0] marked_q;
	logic [MAX_SLOTS-1:0] rem_q;
	logic [SLOT_W-1:0]    ptr_q;
	logic                 hit_s1;
	logic [SLOT_W-1:0]    idx_s1;
	logic                 last_s1;
	gmw_out_t             result_q;
	logic                 strobe_q;

	logic [SLOT_W-1:0]    slot;
	logic [SLOT_W-1:0]    rd_addr;
	logic [CNT_W-1:0]     new_count;
	logic                 in_range;
	logic                 slot_marked;
	logic                 mark_ok;
	logic [MASK_BITS-1:0] mark_mask;
	logic [MAX_SLOTS-1:0] rem_clr;
	logic                 rem_bit;

	assign slot        = idx_q[SLOT_W-1:0];
	assign rd_addr     = ctl.load ? item.chunk_index[SLOT_W-1:0] : ptr_q;
	assign new_count   = (chunk_q > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : chunk_q;
	assign in_range    = idx_q < {{(IDX_W-CNT_W){1'b0}}, active_q};
	assign slot_marked = in_range && marked_q[slot];
	assign mark_ok     = in_range && (src_q != '0);
	assign mark_mask   = marked_q[slot] ? (rd_q | src_q) : src_q;
	assign rem_bit     = rem_q[ptr_q];
	assign rem_clr     = rem_q & ~(MAX_SLOTS'(1) << ptr_q);

	assign sts.drain_go  = (cmd_q == CMD_DRAIN) && (marked_q != '0);
	assign sts.step_last = rem_bit && (rem_clr == '0);

	// mask store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ctl.exec && cmd_q == CMD_MARK && mark_ok) begin
			mask_mem[slot] <= mark_mask;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mask_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= item.cmd;
			idx_q <= item.chunk_index;
			src_q <= item.source_mask;
		end
		if (ctl.exec) begin
			ptr_q <= '0;
			rem_q <= marked_q;
		end else if (ctl.step) begin
			ptr_q <= ptr_q + SLOT_W'(1);
			rem_q <= rem_clr;
		end
		idx_s1   <= ptr_q;
		last_s1  <= rem_clr == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q  <= CNT_W'(MAX_SLOTS);
			active_q <= '0;
			marked_q <= '0;
			hit_s1   <= 1'b0;
		end else begin
			if (cfg_we) chunk_q <= cfg_wdata;
			// per-frame marks: a new frame always drops every mark
			if (ctl.exec && cmd_q == CMD_BEGIN) begin
				active_q <= new_count;
				marked_q <= '0;
			end else if (ctl.exec && cmd_q == CMD_MARK && mark_ok) begin
				marked_q[slot] <= 1'b1;
			end
			hit_s1 <= ctl.step && rem_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (ctl.exec && cmd_q != CMD_BEGIN && !sts.drain_go) || hit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (hit_s1) begin
			result_q.added      <= 1'b0;
			result_q.found      <= 1'b1;
			result_q.slot_index <= 6'(idx_s1);
			result_q.slot_mask  <= rd_q;
			result_q.last       <= last_s1;
		end else if (ctl.exec) begin
			result_q.added      <= 1'b0;
			result_q.found      <= 1'b0;
			result_q.slot_index <= '0;
			result_q.slot_mask  <= '0;
			result_q.last       <= 1'b1;
			case (cmd_q)
				CMD_MARK: begin
					if (mark_ok) begin
						result_q.added     <= !marked_q[slot];
						result_q.slot_mask <= mark_mask;
					end
				end
				CMD_QUERY: begin
					if (slot_marked) begin
						result_q.found     <= 1'b1;
						result_q.slot_mask <= rd_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign result        = result_q;
	assign result_strobe = strobe_q;

endmodule

`default_nettype wire

>>> tb/sv/generation_marked_worklist_checker.sv
`timescale 1ns / 1ps

// watches the command and result channels, keeps a shadow of the worklist and checks every
// result word against the oldest prediction
module generation_marked_worklist_checker
	import gmw_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  gmw_in_t              item,
	input  logic                 cfg_we,
	input  logic [CNT_W-1:0]     cfg_wdata,
	input  gmw_out_t             result,
	input  logic                 result_strobe,
	output int                   fail_count,
	output int                   pending_words
);

	logic [7:0]           slot_gen  [MAX_SLOTS];
	logic [MASK_BITS-1:0] slot_bits [MAX_SLOTS];
	logic [7:0]           frame_gen;
	logic [CNT_W-1:0]     live_count;
	logic [CNT_W-1:0]     chunk_reg;
	gmw_out_t             words_due [$];
	int                   mismatches;

	function automatic gmw_out_t make_word(input logic added, input logic found,
			input logic [5:0] idx, input logic [MASK_BITS-1:0] mask, input logic last);
		gmw_out_t w;
		w.added      = added;
		w.found      = found;
		w.slot_index = idx;
		w.slot_mask  = mask;
		w.last       = last;
		return w;
	endfunction

	task automatic queue_word(input gmw_out_t w);
		words_due.insert(words_due.size(), w);
	endtask

	task automatic clear_tags();
		for (int i = 0; i < MAX_SLOTS; i++) begin
			slot_gen[i] = '0;
		end
	endtask

	function automatic logic slot_live(input int i);
		return (i < int'(live_count)) && (slot_gen[i] == frame_gen);
	endfunction

	task automatic step_worklist(input gmw_in_t w);
		logic [CNT_W-1:0] n;
		logic [5:0]       s;
		int               hits;
		gmw_out_t         tail;
		s = w.chunk_index[SLOT_W-1:0];
		case (gmw_cmd_t'(w.cmd))
			CMD_BEGIN: begin
				n = (chunk_reg > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : chunk_reg;
				if (n != live_count) begin
					live_count = n;
					clear_tags();
					frame_gen = '0;
				end
				frame_gen = frame_gen + 8'd1;
				// tag wrapped: old tags could alias the new generation
				if (frame_gen == '0) begin
					clear_tags();
					frame_gen = 8'd1;
				end
			end
			CMD_MARK: begin
				if ({1'b0, w.chunk_index} >= {2'b0, live_count} || w.source_mask == '0) begin
					queue_word(make_word(1'b0, 1'b0, '0, '0, 1'b1));
				end else if (slot_gen[s] != frame_gen) begin
					slot_gen[s]  = frame_gen;
					slot_bits[s] = w.source_mask;
					queue_word(make_word(1'b1, 1'b0, '0, slot_bits[s], 1'b1));
				end else begin
					slot_bits[s] = slot_bits[s] | w.source_mask;
					queue_word(make_word(1'b0, 1'b0, '0, slot_bits[s], 1'b1));
				end
			end
			CMD_QUERY: begin
				if (int'(w.chunk_index) < int'(live_count) && slot_live(int'(s))) begin
					queue_word(make_word(1'b0, 1'b1, '0, slot_bits[s], 1'b1));
				end else begin
					queue_word(make_word(1'b0, 1'b0, '0, '0, 1'b1));
				end
			end
			default: begin
				hits = 0;
				for (int i = 0; i < MAX_SLOTS; i++) begin
					if (slot_live(i)) begin
						queue_word(make_word(1'b0, 1'b1, 6'(i), slot_bits[i], 1'b0));
						hits++;
					end
				end
				if (hits == 0) begin
					queue_word(make_word(1'b0, 1'b0, '0, '0, 1'b1));
				end else begin
					tail = words_due[words_due.size() - 1];
					tail.last = 1'b1;
					words_due[words_due.size() - 1] = tail;
				end
			end
		endcase
	endtask

	task automatic check_word(input gmw_out_t got);
		gmw_out_t want;
		if (words_due.size() == 0) begin
			$error("result word with nothing outstanding: mask %h index %0d",
				got.slot_mask, got.slot_index);
			mismatches++;
		end else begin
			want = words_due.pop_front();
			if (got.added !== want.added) begin
				$error("added: expected %0d, got %0d", want.added, got.added);
				mismatches++;
			end
			if (got.found !== want.found) begin
				$error("found: expected %0d, got %0d", want.found, got.found);
				mismatches++;
			end
			if (got.slot_index !== want.slot_index) begin
				$error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
				mismatches++;
			end
			if (got.slot_mask !== want.slot_mask) begin
				$error("slot_mask: expected %h, got %h", want.slot_mask, got.slot_mask);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_tags();
			for (int i = 0; i < MAX_SLOTS; i++) begin
				slot_bits[i] = '0;
			end
			frame_gen  = '0;
			live_count = '0;
			chunk_reg  = CNT_W'(MAX_SLOTS);
			words_due.delete();
			mismatches = 0;
			fail_count    <= 0;
			pending_words <= 0;
		end else begin
			// results first: a word leaving now never belongs to an item taken now
			if (result_strobe === 1'b1) begin
				check_word(result);
			end
			if (cfg_we) begin
				chunk_reg = cfg_wdata;
			end
			if (start && !busy) begin
				step_worklist(item);
			end
			fail_count    <= mismatches;
			pending_words <= words_due.size();
		end
	end

endmodule

>>> tb/sv/tb_generation_marked_worklist_core.sv
`timescale 1ns / 1ps

module tb_generation_marked_worklist_core;
	import gmw_pkg::*;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	gmw_in_t          item      = '0;
	logic             cfg_we    = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;
	logic             busy;
	gmw_out_t         result;
	logic             result_strobe;
	int               fail_count;
	int               pending_words;

	bit               idle_en    = 1'b1;
	logic [CNT_W-1:0] cfg_shadow = CNT_W'(MAX_SLOTS);
	int               slots_live = 0;

	generation_marked_worklist_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.result        (result),
		.result_strobe (result_strobe)
	);

	generation_marked_worklist_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.result        (result),
		.result_strobe (result_strobe),
		.fail_count    (fail_count),
		.pending_words (pending_words)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5000000;
		$display("TB_ERROR");
		$finish;
	end

	// start stays high from one word to the next unless an idle cycle is drawn
	task automatic issue(input gmw_cmd_t cmd, input logic [7:0] idx,
			input logic [MASK_BITS-1:0] mask);
		gmw_in_t w;
		w.cmd         = cmd;
		w.chunk_index = idx;
		w.source_mask = mask;
		if (cmd == CMD_BEGIN) begin
			slots_live = (cfg_shadow > MAX_SLOTS) ? MAX_SLOTS : int'(cfg_shadow);
		end
		while (idle_en && $urandom_range(99) < 31) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item  <= w;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain_wait();
		start <= 1'b0;
		@(posedge clk);
		while (pending_words != 0) begin
			@(posedge clk);
		end
	endtask

	// a begin_frame leaves no result behind, so also wait for busy to drop before the write
	task automatic settle_and_write(input logic [CNT_W-1:0] v);
		drain_wait();
		repeat (80) @(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		cfg_we     <= 1'b1;
		cfg_wdata  <= v;
		cfg_shadow = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] pick_index();
		if ($urandom_range(9) == 0 || slots_live == 0) begin
			return 8'($urandom_range(255));
		end
		return 8'($urandom_range(slots_live - 1));
	endfunction

	function automatic logic [MASK_BITS-1:0] pick_mask();
		int r;
		r = $urandom_range(9);
		if (r == 0) begin
			return '0;
		end else if (r < 4) begin
			return MASK_BITS'(1) << $urandom_range(MASK_BITS - 1);
		end
		return MASK_BITS'($urandom);
	endfunction

	task automatic run_mix(input int n);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 8) begin
				issue(CMD_BEGIN, 8'($urandom), MASK_BITS'($urandom));
			end else if (r < 55) begin
				issue(CMD_MARK, pick_index(), pick_mask());
			end else if (r < 80) begin
				issue(CMD_QUERY, pick_index(), MASK_BITS'($urandom));
			end else begin
				issue(CMD_DRAIN, 8'($urandom), MASK_BITS'($urandom));
			end
		end
	endtask

	logic [CNT_W-1:0] plan [8];

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no frame begun yet: nothing can be marked
		issue(CMD_MARK, 8'd0, 32'hFFFF_FFFF);
		issue(CMD_QUERY, 8'd0, '0);
		issue(CMD_DRAIN, 8'd0, '0);
		issue(CMD_BEGIN, 8'd0, '0);
		issue(CMD_MARK, 8'd0, 32'hFFFF_FFFF);
		issue(CMD_MARK, 8'd63, 32'h0000_0001);
		issue(CMD_MARK, 8'd63, 32'h8000_0000);
		issue(CMD_MARK, 8'd64, 32'h0000_0001);
		issue(CMD_MARK, 8'd255, 32'hFFFF_FFFF);
		issue(CMD_MARK, 8'd5, 32'h0000_0000);
		issue(CMD_QUERY, 8'd0, '0);
		issue(CMD_QUERY, 8'd63, '0);
		issue(CMD_QUERY, 8'd5, '0);
		issue(CMD_QUERY, 8'd255, 32'hFFFF_FFFF);
		issue(CMD_DRAIN, 8'd0, '0);
		issue(CMD_BEGIN, 8'd0, '0);
		issue(CMD_QUERY, 8'd0, '0);
		issue(CMD_DRAIN, 8'hFF, 32'hFFFF_FFFF);

		// frames back to back with no idling: a mark never outlives its frame
		settle_and_write(CNT_W'(16));
		idle_en = 1'b0;
		issue(CMD_BEGIN, 8'd0, '0);
		issue(CMD_MARK, 8'd3, 32'h0000_00A5);
		repeat (2) issue(CMD_BEGIN, 8'd0, '0);
		issue(CMD_MARK, 8'd4, 32'h5A00_0000);
		issue(CMD_QUERY, 8'd3, '0);
		issue(CMD_QUERY, 8'd4, '0);
		issue(CMD_BEGIN, 8'd0, '0);
		issue(CMD_QUERY, 8'd3, '0);
		issue(CMD_QUERY, 8'd4, '0);
		issue(CMD_DRAIN, 8'd0, '0);

		// every slot marked, then the longest drain
		settle_and_write(CNT_W'(MAX_SLOTS));
		issue(CMD_BEGIN, 8'd0, '0);
		for (int i = 0; i < MAX_SLOTS; i++) begin
			issue(CMD_MARK, 8'(i), pick_mask() | 32'h1);
		end
		repeat (4) issue(CMD_MARK, 8'($urandom_range(63)), pick_mask());
		issue(CMD_DRAIN, 8'd0, '0);
		idle_en = 1'b1;
		issue(CMD_BEGIN, 8'd0, '0);
		run_mix(20);

		plan[0] = CNT_W'(1);
		plan[1] = CNT_W'(127);
		plan[2] = CNT_W'(0);
		plan[3] = CNT_W'(63);
		plan[4] = CNT_W'(63);
		plan[5] = CNT_W'($urandom_range(127));
		plan[6] = CNT_W'($urandom_range(1, 64));
		plan[7] = CNT_W'(2);
		for (int p = 0; p < 8; p++) begin
			settle_and_write(plan[p]);
			issue(CMD_BEGIN, 8'd0, '0);
			run_mix(18);
		end

		drain_wait();
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending_words == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
